// ===== sv/ordered_list_store_macros.svh =====
// Assertion macros for the ordered list store.
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

`ifndef ASSERT_OFF

`define OLS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define OLS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define OLS_ASSERT(label, clk, rst_n, prop, msg)

`define OLS_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== sv/ols_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package ols_pkg;

    localparam int DEPTH     = 64;
    localparam int VALUE_W   = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = 8;
    localparam int REQ_W     = 3;
    localparam int ERR_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET    = REQ_W'(0),
        REQ_SET    = REQ_W'(1),
        REQ_INSERT = REQ_W'(2),
        REQ_REMOVE = REQ_W'(3),
        REQ_SEARCH = REQ_W'(4),
        REQ_RESIZE = REQ_W'(5)
    } t_req;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK     = ERR_W'(0),
        ERR_RANGE  = ERR_W'(1),
        ERR_STATIC = ERR_W'(2),
        ERR_FULL   = ERR_W'(3)
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DYNAMIC = CFG_IDX_W'(0),
        CFG_FILL    = CFG_IDX_W'(1)
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic chk;
        logic ptr_init;
        logic ptr_inc;
        logic ptr_dec;
        logic rd_pos;
        logic rd_step;
        logic hold_rd;
        logic wr_shift;
        logic wr_data;
        logic wr_fill;
        logic cmp;
        logic cnt_commit;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        t_req op;
        t_err err;
        logic more;
        logic out_free;
    } t_status;

endpackage

// ===== sv/ols_datapath.sv =====
// Datapath: entry memory, length, request latch, walk pointer and result register.
`include "ordered_list_store_macros.svh"

module ols_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ols_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ols_pkg::VALUE_W-1:0]     i_cfg_data,
    input  logic [ols_pkg::REQ_W-1:0]       i_req_type,
    input  logic [ols_pkg::POS_W-1:0]       i_position,
    input  logic [ols_pkg::VALUE_W-1:0]     i_data_in,
    input  logic [ols_pkg::POS_W-1:0]       i_new_length,
    input  ols_pkg::t_cmd                   i_cmd,
    output ols_pkg::t_status                o_status,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [ols_pkg::VALUE_W-1:0]     o_read_value,
    output logic                            o_found,
    output logic [ols_pkg::ERR_W-1:0]       o_error_code,
    output logic [ols_pkg::LEN_W-1:0]       o_length_now
);

    localparam int                       LEN_W   = ols_pkg::LEN_W;
    localparam int                       CMP_W   = ols_pkg::CMP_W;
    localparam int                       ADDR_W  = ols_pkg::ADDR_W;
    localparam logic [CMP_W-1:0]         DEPTH_C = CMP_W'(ols_pkg::DEPTH);

    logic [ols_pkg::VALUE_W-1:0] r_store [ols_pkg::DEPTH];
    logic [ols_pkg::VALUE_W-1:0] r_rdata;

    logic                        r_dyn;
    logic [ols_pkg::VALUE_W-1:0] r_fill;

    ols_pkg::t_req               r_op;
    logic [ols_pkg::POS_W-1:0]   r_pos;
    logic [ols_pkg::VALUE_W-1:0] r_data;
    logic [ols_pkg::POS_W-1:0]   r_newlen;

    logic [LEN_W-1:0]            r_count;
    logic [LEN_W-1:0]            n_count;
    logic [LEN_W-1:0]            r_ptr;
    logic [LEN_W-1:0]            n_ptr;
    logic                        r_found;
    logic [ols_pkg::VALUE_W-1:0] r_value;
    ols_pkg::t_err               r_err;

    logic                        r_out_valid;
    logic [ols_pkg::VALUE_W-1:0] r_out_value;
    logic                        r_out_found;
    ols_pkg::t_err               r_out_err;
    logic [LEN_W-1:0]            r_out_len;

    logic [CMP_W-1:0]            pos_c;
    logic [CMP_W-1:0]            cnt_c;
    logic [CMP_W-1:0]            nl_c;
    logic [CMP_W-1:0]            ptr_c;
    ols_pkg::t_err               err_c;
    logic                        more_c;
    logic [LEN_W-1:0]            ptr_start;
    logic [LEN_W-1:0]            rd_full;
    logic [LEN_W-1:0]            wr_full;
    logic [ols_pkg::VALUE_W-1:0] wr_val;
    logic                        wr_en;
    logic                        rd_en;

    assign pos_c = CMP_W'(r_pos);
    assign cnt_c = CMP_W'(r_count);
    assign nl_c  = CMP_W'(r_newlen);
    assign ptr_c = CMP_W'(r_ptr);

    always_comb begin
        err_c = ols_pkg::ERR_OK;
        case (r_op)
            ols_pkg::REQ_GET, ols_pkg::REQ_SET: begin
                if (pos_c >= cnt_c) err_c = ols_pkg::ERR_RANGE;
            end
            ols_pkg::REQ_INSERT: begin
                if (!r_dyn)                err_c = ols_pkg::ERR_STATIC;
                else if (pos_c > cnt_c)    err_c = ols_pkg::ERR_RANGE;
                else if (cnt_c >= DEPTH_C) err_c = ols_pkg::ERR_FULL;
            end
            ols_pkg::REQ_REMOVE: begin
                if (!r_dyn)              err_c = ols_pkg::ERR_STATIC;
                else if (pos_c >= cnt_c) err_c = ols_pkg::ERR_RANGE;
            end
            ols_pkg::REQ_RESIZE: begin
                if (!r_dyn)               err_c = ols_pkg::ERR_STATIC;
                else if (nl_c > DEPTH_C)  err_c = ols_pkg::ERR_FULL;
            end
            default: err_c = ols_pkg::ERR_OK;
        endcase
    end

    always_comb begin
        case (r_op)
            ols_pkg::REQ_INSERT: more_c = ptr_c > pos_c;
            ols_pkg::REQ_REMOVE: more_c = (ptr_c + CMP_W'(1)) < cnt_c;
            ols_pkg::REQ_SEARCH: more_c = (ptr_c < cnt_c) && !r_found;
            ols_pkg::REQ_RESIZE: more_c = ptr_c < nl_c;
            default:             more_c = 1'b0;
        endcase
    end

    always_comb begin
        case (r_op)
            ols_pkg::REQ_INSERT, ols_pkg::REQ_RESIZE: ptr_start = r_count;
            ols_pkg::REQ_REMOVE:                      ptr_start = LEN_W'(r_pos);
            default:                                  ptr_start = '0;
        endcase
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_init)     n_ptr = ptr_start;
        else if (i_cmd.ptr_inc) n_ptr = r_ptr + LEN_W'(1);
        else if (i_cmd.ptr_dec) n_ptr = r_ptr - LEN_W'(1);
    end

    always_comb begin
        case (r_op)
            ols_pkg::REQ_INSERT: n_count = r_count + LEN_W'(1);
            ols_pkg::REQ_REMOVE: n_count = r_count - LEN_W'(1);
            ols_pkg::REQ_RESIZE: n_count = LEN_W'(r_newlen);
            default:             n_count = r_count;
        endcase
    end

    always_comb begin
        if (i_cmd.rd_pos) begin
            rd_full = LEN_W'(r_pos);
        end else begin
            case (r_op)
                ols_pkg::REQ_INSERT: rd_full = r_ptr - LEN_W'(1);
                ols_pkg::REQ_REMOVE: rd_full = r_ptr + LEN_W'(1);
                default:             rd_full = r_ptr;
            endcase
        end
    end

    always_comb begin
        if (i_cmd.wr_data) begin
            wr_full = LEN_W'(r_pos);
            wr_val  = r_data;
        end else if (i_cmd.wr_fill) begin
            wr_full = r_ptr;
            wr_val  = r_fill;
        end else begin
            wr_full = r_ptr;
            wr_val  = r_rdata;
        end
    end

    assign rd_en = i_cmd.rd_pos | i_cmd.rd_step;
    assign wr_en = i_cmd.wr_data | i_cmd.wr_fill | i_cmd.wr_shift;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_full[ADDR_W-1:0]] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_store[rd_full[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn  <= 1'b1;
            r_fill <= '0;
        end else if (i_cfg_we) begin
            case (ols_pkg::t_cfg_idx'(i_cfg_index))
                ols_pkg::CFG_DYNAMIC: r_dyn  <= i_cfg_data[0];
                ols_pkg::CFG_FILL:    r_fill <= i_cfg_data;
                default:              r_dyn  <= r_dyn;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= ols_pkg::t_req'(i_req_type);
            r_pos    <= i_position;
            r_data   <= i_data_in;
            r_newlen <= i_new_length;
        end
        r_ptr <= n_ptr;
        if (i_cmd.chk) r_err <= err_c;
        if (i_cmd.load) begin
            r_value <= '0;
        end else if (i_cmd.hold_rd) begin
            r_value <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.cnt_commit) r_count <= n_count;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_cmd.cmp && (r_rdata == r_data)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_value <= r_value;
            r_out_found <= r_found;
            r_out_err   <= r_err;
            r_out_len   <= r_count;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.err      = err_c;
    assign o_status.more     = more_c;
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_found      = r_out_found;
    assign o_error_code = r_out_err;
    assign o_length_now = r_out_len;

    `OLS_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= LEN_W'(ols_pkg::DEPTH), "length beyond capacity")
    `OLS_ASSERT(a_count_hold, i_clk, i_rst_n, !i_cmd.cnt_commit |=> $stable(r_count), "length moved without commit")
    `OLS_ASSERT(a_found_search, i_clk, i_rst_n, r_found |-> (r_op == ols_pkg::REQ_SEARCH), "found set outside search")

endmodule

// ===== sv/ols_ctrl.sv =====
// Controller: sequences each request over the datapath.
`include "ordered_list_store_macros.svh"

module ols_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output ols_pkg::t_cmd    o_cmd,
    input  ols_pkg::t_status i_status
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_CAPTURE  = 6'b000100,
        S_LOOP     = 6'b001000,
        S_MOVE     = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    ols_pkg::t_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.chk = 1'b1;
                if (i_status.err != ols_pkg::ERR_OK) begin
                    n_state = S_DONE;
                end else begin
                    case (i_status.op)
                        ols_pkg::REQ_GET: begin
                            cmd.rd_pos = 1'b1;
                            n_state    = S_CAPTURE;
                        end
                        ols_pkg::REQ_SET: begin
                            cmd.wr_data = 1'b1;
                            n_state     = S_DONE;
                        end
                        ols_pkg::REQ_REMOVE: begin
                            cmd.rd_pos   = 1'b1;
                            cmd.ptr_init = 1'b1;
                            n_state      = S_CAPTURE;
                        end
                        ols_pkg::REQ_INSERT, ols_pkg::REQ_SEARCH, ols_pkg::REQ_RESIZE: begin
                            cmd.ptr_init = 1'b1;
                            n_state      = S_LOOP;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CAPTURE: begin
                cmd.hold_rd = 1'b1;
                n_state = (i_status.op == ols_pkg::REQ_REMOVE) ? S_LOOP : S_DONE;
            end
            S_LOOP: begin
                if (i_status.more) begin
                    if (i_status.op == ols_pkg::REQ_RESIZE) begin
                        cmd.wr_fill = 1'b1;
                        cmd.ptr_inc = 1'b1;
                    end else begin
                        cmd.rd_step = 1'b1;
                        n_state     = S_MOVE;
                    end
                end else begin
                    cmd.wr_data    = (i_status.op == ols_pkg::REQ_INSERT);
                    cmd.cnt_commit = i_status.op inside {ols_pkg::REQ_INSERT,
                                                         ols_pkg::REQ_REMOVE,
                                                         ols_pkg::REQ_RESIZE};
                    n_state        = S_DONE;
                end
            end
            S_MOVE: begin
                case (i_status.op)
                    ols_pkg::REQ_INSERT: begin
                        cmd.wr_shift = 1'b1;
                        cmd.ptr_dec  = 1'b1;
                    end
                    ols_pkg::REQ_REMOVE: begin
                        cmd.wr_shift = 1'b1;
                        cmd.ptr_inc  = 1'b1;
                    end
                    default: begin
                        cmd.cmp     = 1'b1;
                        cmd.ptr_inc = 1'b1;
                    end
                endcase
                n_state = S_LOOP;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;

    `OLS_ASSERT(a_load_free, i_clk, i_rst_n, cmd.res_load |-> i_status.out_free, "result loaded over a held item")
    `OLS_ASSERT(a_err_done, i_clk, i_rst_n, (r_state == S_DISPATCH && i_status.err != ols_pkg::ERR_OK) |=> (r_state == S_DONE), "failed request touched the list")

endmodule

// ===== sv/ordered_list_store.sv =====
// Ordered list store: get, set, insert, remove, search and resize on a 64-entry list.
// Insert and remove shift the entries past the position, search scans from the head
// until a match or the end of the list, and resize writes the fill value into new entries.
// One item at a time; the shift and scan walk one memory port, entry by entry.
// The next item is taken once the previous result has moved into the output register.
// Synchronous reset clears the length and the control state; entry contents are not cleared.
module ordered_list_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ols_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ols_pkg::VALUE_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ols_pkg::REQ_W-1:0]       i_req_type,
    input  logic [ols_pkg::POS_W-1:0]       i_position,
    input  logic [ols_pkg::VALUE_W-1:0]     i_data_in,
    input  logic [ols_pkg::POS_W-1:0]       i_new_length,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ols_pkg::VALUE_W-1:0]     o_read_value,
    output logic                            o_found,
    output logic [ols_pkg::ERR_W-1:0]       o_error_code,
    output logic [ols_pkg::LEN_W-1:0]       o_length_now
);

    ols_pkg::t_cmd    cmd;
    ols_pkg::t_status status;

    ols_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    ols_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_data_in    (i_data_in),
        .i_new_length (i_new_length),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_found      (o_found),
        .o_error_code (o_error_code),
        .o_length_now (o_length_now)
    );

endmodule

// ===== verif/ordered_list_store_tb.sv =====
// Testbench for ordered_list_store: directed and random list requests checked against a shadow list.
`timescale 1ns / 1ps

module ordered_list_store_tb;
    import ols_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 150;
    localparam int SEGMENT_ITEMS = 40;
    localparam int PHASE_ITEMS   = 200;
    localparam int MAX_PRINTED   = 40;

    localparam logic [REQ_W-1:0] REQ_SPARE_LO = REQ_W'(6);
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = REQ_W'(7);

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [VALUE_W-1:0] value;
        logic               found;
        t_err               err;
        logic [LEN_W-1:0]   length;
    } t_list_result;

    class list_shadow;
        logic [VALUE_W-1:0] words [DEPTH];
        int unsigned        count      = 0;
        bit                 dynamic_en = 1'b1;
        logic [VALUE_W-1:0] fill       = '0;
        t_list_result       due_results [$];
        int unsigned        requests   = 0;
        int unsigned        results    = 0;
        int unsigned        mismatches = 0;
        int unsigned        hits       = 0;
        int unsigned        err_seen [4] = '{0, 0, 0, 0};

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
            case (idx)
                CFG_DYNAMIC: dynamic_en = data[0];
                CFG_FILL:    fill = data;
                default: ;
            endcase
        endfunction

        function void apply_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                    logic [VALUE_W-1:0] data, logic [POS_W-1:0] nlen);
            t_list_result r;
            int           i;
            r.req   = req;
            r.value = '0;
            r.found = 1'b0;
            r.err   = ERR_OK;
            case (req)
                REQ_GET: begin
                    if (pos >= count) r.err = ERR_RANGE;
                    else r.value = words[pos];
                end
                REQ_SET: begin
                    if (pos >= count) r.err = ERR_RANGE;
                    else words[pos] = data;
                end
                REQ_INSERT: begin
                    if (!dynamic_en) r.err = ERR_STATIC;
                    else if (pos > count) r.err = ERR_RANGE;
                    else if (count >= DEPTH) r.err = ERR_FULL;
                    else begin
                        for (i = count; i > pos; i--) words[i] = words[i-1];
                        words[pos] = data;
                        count++;
                    end
                end
                REQ_REMOVE: begin
                    if (!dynamic_en) r.err = ERR_STATIC;
                    else if (pos >= count) r.err = ERR_RANGE;
                    else begin
                        r.value = words[pos];
                        for (i = pos; i + 1 < count; i++) words[i] = words[i+1];
                        count--;
                    end
                end
                REQ_SEARCH: begin
                    for (i = 0; i < count; i++) begin
                        if (words[i] == data) r.found = 1'b1;
                    end
                end
                REQ_RESIZE: begin
                    if (!dynamic_en) r.err = ERR_STATIC;
                    else if (nlen > DEPTH) r.err = ERR_FULL;
                    else begin
                        for (i = count; i < nlen; i++) words[i] = fill;
                        count = 32'(nlen);
                    end
                end
                default: ;
            endcase
            r.length = LEN_W'(count);
            requests++;
            err_seen[r.err]++;
            if (r.found) hits++;
            due_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_result(logic [VALUE_W-1:0] value, logic found,
                            logic [ERR_W-1:0] err, logic [LEN_W-1:0] length);
            t_list_result w;
            if (due_results.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                w = due_results.pop_front();
                results++;
                if (value !== w.value)
                    report($sformatf("result %0d req %0d read_value %0h, expected %0h",
                                     results, w.req, value, w.value));
                if (found !== w.found)
                    report($sformatf("result %0d req %0d found %0b, expected %0b",
                                     results, w.req, found, w.found));
                if (err !== w.err)
                    report($sformatf("result %0d req %0d error_code %0d, expected %0d",
                                     results, w.req, err, w.err));
                if (length !== w.length)
                    report($sformatf("result %0d req %0d length_now %0d, expected %0d",
                                     results, w.req, length, w.length));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [VALUE_W-1:0]   i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic [POS_W-1:0]     i_position;
    logic [VALUE_W-1:0]   i_data_in;
    logic [POS_W-1:0]     i_new_length;
    logic                 o_valid;
    logic                 i_stall;
    logic [VALUE_W-1:0]   o_read_value;
    logic                 o_found;
    logic [ERR_W-1:0]     o_error_code;
    logic [LEN_W-1:0]     o_length_now;

    list_shadow  sb;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          hold_req    = 1'b0;
    int unsigned cycles;

    ordered_list_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_data_in    (i_data_in),
        .i_new_length (i_new_length),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_found      (o_found),
        .o_error_code (o_error_code),
        .o_length_now (o_length_now)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.compare_result(o_read_value, o_found, o_error_code, o_length_now);
            if (i_cfg_we)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall)
                sb.apply_request(i_req_type, i_position, i_data_in, i_new_length);
        end
    end

    // Receiver: random stall, or a long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, sb.due_results.size());
        $display("** ordered_list_store: FAILED **");
        $finish;
    end

    task automatic offer(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                         input logic [VALUE_W-1:0] data, input logic [POS_W-1:0] nlen);
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_position   <= pos;
        i_data_in    <= data;
        i_new_length <= nlen;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                             input logic [VALUE_W-1:0] data, input logic [POS_W-1:0] nlen);
        @(negedge i_clk);
        offer(req, pos, data, nlen);
    endtask

    task automatic sender_gap();
        int unsigned gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic pause_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.due_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic configure_random();
        write_reg(CFG_DYNAMIC, VALUE_W'($urandom_range(0, 3) != 0));
        case ($urandom_range(0, 2))
            0:       write_reg(CFG_FILL, '0);
            1:       write_reg(CFG_FILL, '1);
            default: write_reg(CFG_FILL, $urandom);
        endcase
    endtask

    task automatic send_random();
        logic [REQ_W-1:0]   req;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] data;
        logic [POS_W-1:0]   nlen;
        int unsigned        len;
        int unsigned        pick;
        int unsigned        sel;
        @(negedge i_clk);
        len  = sb.count;
        pick = $urandom_range(0, 99);
        data = $urandom;
        pos  = POS_W'($urandom_range(0, 255));
        nlen = POS_W'($urandom_range(0, 255));
        if (pick < 16) req = REQ_GET;
        else if (pick < 28) req = REQ_SET;
        else if (pick < 50) req = (len > 24 && $urandom_range(0, 1)) ? REQ_REMOVE : REQ_INSERT;
        else if (pick < 68) req = REQ_REMOVE;
        else if (pick < 82) req = REQ_SEARCH;
        else if (pick < 94) req = REQ_RESIZE;
        else if (pick < 97) req = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
        else req = REQ_W'($urandom_range(0, 7));
        if (pick < 97) begin
            // keep most positions inside the list
            if ($urandom_range(0, 99) < 85) begin
                if (req == REQ_INSERT) pos = POS_W'($urandom_range(0, len));
                else if (len > 0) pos = POS_W'($urandom_range(0, len - 1));
            end
            if (req == REQ_SEARCH && len > 0 && $urandom_range(0, 9) < 6)
                data = sb.words[$urandom_range(0, len - 1)];
            if (req == REQ_RESIZE) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) nlen = POS_W'($urandom_range(0, 16));
                else if (sel < 85) nlen = POS_W'($urandom_range(0, DEPTH));
                else if (sel < 92) nlen = POS_W'(DEPTH);
                else nlen = POS_W'($urandom_range(DEPTH + 1, 255));
            end
        end
        offer(req, pos, data, nlen);
    endtask

    task automatic run_phase(input int unsigned tx, input int unsigned rx, input int n);
        @(posedge i_clk);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        for (int k = 0; k < n; k++) begin
            if (k % SEGMENT_ITEMS == 0) begin
                pause_input();
                drain();
                configure_random();
            end
            sender_gap();
            send_random();
            if (k == n / 2) hold_req = 1'b1;
        end
    endtask

    initial begin
        sb           = new();
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_DYNAMIC;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_req_type   = REQ_GET;
        i_position   = '0;
        i_data_in    = '0;
        i_new_length = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_FILL, '1);
        send_item(REQ_SEARCH, 8'd0, 32'h0, 8'd0);
        send_item(REQ_GET, 8'd0, 32'h0, 8'd0);
        send_item(REQ_REMOVE, 8'd0, 32'h0, 8'd0);
        send_item(REQ_INSERT, 8'd1, 32'h0, 8'd0);
        send_item(REQ_INSERT, 8'd0, 32'h0, 8'd0);
        send_item(REQ_INSERT, 8'd1, 32'hFFFF_FFFF, 8'd0);
        send_item(REQ_INSERT, 8'd0, 32'hA5A5_5A5A, 8'd0);
        send_item(REQ_RESIZE, 8'd0, 32'h0, 8'(DEPTH + 1));
        send_item(REQ_RESIZE, 8'd0, 32'h0, 8'(DEPTH));
        send_item(REQ_INSERT, 8'(DEPTH), 32'h5555_AAAA, 8'd0);
        send_item(REQ_GET, 8'(DEPTH - 1), 32'h0, 8'd0);
        send_item(REQ_GET, 8'hFF, 32'h0, 8'd0);
        send_item(REQ_SET, 8'(DEPTH), 32'h0, 8'd0);
        send_item(REQ_SET, 8'(DEPTH - 1), 32'h1234_5678, 8'd0);
        send_item(REQ_SEARCH, 8'd0, 32'h1234_5678, 8'd0);
        send_item(REQ_REMOVE, 8'd0, 32'h0, 8'd0);
        send_item(REQ_REMOVE, 8'(DEPTH - 2), 32'h0, 8'd0);
        send_item(REQ_RESIZE, 8'd0, 32'h0, 8'hFF);
        send_item(REQ_RESIZE, 8'd0, 32'h0, 8'd5);
        send_item(REQ_SPARE_LO, POS_W'($urandom_range(0, 255)), $urandom,
                  POS_W'($urandom_range(0, 255)));
        send_item(REQ_SPARE_HI, POS_W'($urandom_range(0, 255)), $urandom,
                  POS_W'($urandom_range(0, 255)));
        pause_input();
        drain();
        write_reg(CFG_DYNAMIC, '0);
        write_reg(CFG_FILL, '0);
        send_item(REQ_INSERT, 8'hFF, 32'h0, 8'd0);
        send_item(REQ_REMOVE, 8'd0, 32'h0, 8'd0);
        send_item(REQ_RESIZE, 8'd0, 32'h0, 8'd0);
        send_item(REQ_GET, 8'd4, 32'h0, 8'd0);
        send_item(REQ_SET, 8'd4, 32'hDEAD_BEEF, 8'd0);
        pause_input();
        drain();
        write_reg(CFG_DYNAMIC, 1);

        run_phase(32, 71, PHASE_ITEMS);
        run_phase(71, 32, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        pause_input();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results checked, %0d search hits", sb.requests,
                 sb.results, sb.hits);
        $display("errors predicted: %0d range, %0d not dynamic, %0d capacity; %0d mismatches",
                 sb.err_seen[ERR_RANGE], sb.err_seen[ERR_STATIC], sb.err_seen[ERR_FULL],
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
            $display("** ordered_list_store: PASSED **");
        end else begin
            $display("** ordered_list_store: FAILED **");
        end
        $finish;
    end
endmodule
